@@ design/tqbs_pkg.sv @@
// ----------------------------------------------------------------------------
// tqbs_pkg
// Shared types and constants of the triple-quoted block string scanner:
// transfer payloads, verdict codes, character codes and the character class
// bundle passed from the decoder to the scan core.
// ----------------------------------------------------------------------------
package tqbs_pkg;

  // Default width of the saturating token length counter.
  localparam int unsigned LengthBitsDef = 16;
  // Width of the token length field in a result transfer.
  localparam int unsigned TokenLenW = 16;

  // Character codes.
  localparam logic [7:0] ChQuote     = 8'h27;  // '
  localparam logic [7:0] ChBar       = 8'h7C;  // |
  localparam logic [7:0] ChGreater   = 8'h3E;  // >
  localparam logic [7:0] ChBackslash = 8'h5C;  // backslash
  localparam logic [7:0] ChDash      = 8'h2D;  // -
  localparam logic [7:0] ChHash      = 8'h23;  // #
  localparam logic [7:0] ChComma     = 8'h2C;  // ,
  localparam logic [7:0] ChRParen    = 8'h29;  // )
  localparam logic [7:0] ChRBrace    = 8'h7D;  // }
  localparam logic [7:0] ChRBracket  = 8'h5D;  // ]
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChNul       = 8'h00;

  typedef enum logic [1:0] {
    VerdictIdle   = 2'd0,
    VerdictScan   = 2'd1,
    VerdictAccept = 2'd2,
    VerdictReject = 2'd3
  } verdict_e;

  typedef struct packed {
    logic       start_scan;
    logic       token_allowed;
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           verdict;
    logic                 in_token;
    logic [TokenLenW-1:0] token_length;
  } out_item_t;

  // Decoded properties of the current character.
  typedef struct packed {
    logic is_end;        // NUL or end of input
    logic is_space_tab;
    logic is_cr;
    logic is_lf;
    logic is_quote;
    logic is_kind;       // block kind indicator after the opening quotes
    logic is_dash;
    logic is_follower;   // may follow the closing quotes
  } char_class_t;

endpackage

@@ design/tqbs_char_class.sv @@
// ----------------------------------------------------------------------------
// tqbs_char_class
// Decodes one input character into the class flags used by the scan core.
// End of input forces the character to NUL.
// ----------------------------------------------------------------------------
module tqbs_char_class (
  input  logic [7:0]           char_code_i,
  input  logic                 end_of_input_i,
  output tqbs_pkg::char_class_t class_o
);

  logic [7:0] ch;

  assign ch = end_of_input_i ? tqbs_pkg::ChNul : char_code_i;

  always_comb begin
    class_o.is_end       = (ch == tqbs_pkg::ChNul);
    class_o.is_space_tab = (ch == tqbs_pkg::ChSpace) || (ch == tqbs_pkg::ChTab);
    class_o.is_cr        = (ch == tqbs_pkg::ChCr);
    class_o.is_lf        = (ch == tqbs_pkg::ChLf);
    class_o.is_quote     = (ch == tqbs_pkg::ChQuote);
    class_o.is_kind      = (ch == tqbs_pkg::ChBar) || (ch == tqbs_pkg::ChGreater) ||
                           (ch == tqbs_pkg::ChBackslash);
    class_o.is_dash      = (ch == tqbs_pkg::ChDash);
    class_o.is_follower  = (ch == tqbs_pkg::ChNul) || (ch == tqbs_pkg::ChLf) ||
                           (ch == tqbs_pkg::ChCr) || (ch == tqbs_pkg::ChSpace) ||
                           (ch == tqbs_pkg::ChTab) || (ch == tqbs_pkg::ChComma) ||
                           (ch == tqbs_pkg::ChRParen) || (ch == tqbs_pkg::ChRBrace) ||
                           (ch == tqbs_pkg::ChRBracket) || (ch == tqbs_pkg::ChHash);
  end

endmodule

@@ design/tqbs_core.sv @@
// ----------------------------------------------------------------------------
// tqbs_core
// Scan state machine. Holds the phase, the quote counter and the saturating
// token length, and computes the result for the character presented while
// advance_i is high. State moves only when advance_i is high.
// ----------------------------------------------------------------------------
module tqbs_core #(
  parameter int unsigned LENGTH_BITS = tqbs_pkg::LengthBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               advance_i,
  input  logic                               start_scan_i,
  input  logic                               token_allowed_i,
  input  tqbs_pkg::char_class_t              class_i,
  output tqbs_pkg::verdict_e                 verdict_o,
  output logic                               in_token_o,
  output logic [tqbs_pkg::TokenLenW-1:0]     token_length_o
);

  localparam int unsigned ExtBits =
      (LENGTH_BITS > tqbs_pkg::TokenLenW) ? LENGTH_BITS : tqbs_pkg::TokenLenW;

  typedef enum logic [3:0] {
    PhIdle,
    PhLead,
    PhOpenQuotes,
    PhOpenKind,
    PhOpenDash,
    PhOpenSpace,
    PhOpenLf,
    PhLineIndent,
    PhCloseQuotes,
    PhCloseFollow,
    PhSkipLine
  } phase_e;

  phase_e                 phase_q, phase_d, ph;
  logic [1:0]             quote_q, quote_d, qc;
  logic [LENGTH_BITS-1:0] len_q, len_d, len_base, len_inc, len_shown;
  logic [ExtBits-1:0]     len_ext;
  logic                   took, reject, accept;

  always_comb begin
    ph       = start_scan_i ? PhLead : phase_q;
    qc       = start_scan_i ? 2'd0 : quote_q;
    len_base = start_scan_i ? '0 : len_q;

    // Phases that fall through to another phase without consuming the character.
    if ((ph == PhLead) && !(class_i.is_space_tab || class_i.is_cr || class_i.is_lf)) begin
      ph = PhOpenQuotes;
      qc = 2'd0;
    end
    if ((ph == PhOpenDash) && !class_i.is_dash) begin
      ph = PhOpenSpace;
    end
    if ((ph == PhLineIndent) && !class_i.is_space_tab) begin
      ph = PhCloseQuotes;
      qc = 2'd0;
    end
    if ((ph == PhCloseQuotes) && !class_i.is_quote) begin
      ph = PhSkipLine;
      qc = 2'd0;
    end
    if ((ph == PhCloseFollow) && !class_i.is_follower) begin
      ph = PhSkipLine;
    end

    phase_d = ph;
    quote_d = qc;
    took    = 1'b0;
    reject  = 1'b0;
    accept  = 1'b0;

    unique case (ph)
      PhIdle: ;
      PhLead: ;  // leading whitespace is skipped
      PhOpenQuotes, PhCloseQuotes: begin
        if (class_i.is_quote) begin
          took = 1'b1;
          if (qc == 2'd2) begin
            quote_d = 2'd0;
            phase_d = (ph == PhOpenQuotes) ? PhOpenKind : PhCloseFollow;
          end else begin
            quote_d = qc + 2'd1;
          end
        end else begin
          reject = 1'b1;
        end
      end
      PhOpenKind: begin
        if (class_i.is_kind) begin
          took    = 1'b1;
          phase_d = PhOpenDash;
        end else begin
          reject = 1'b1;
        end
      end
      PhOpenDash: begin
        took    = 1'b1;
        phase_d = PhOpenSpace;
      end
      PhOpenSpace: begin
        took = 1'b1;
        if (class_i.is_cr) begin
          phase_d = PhOpenLf;
        end else if (class_i.is_lf) begin
          phase_d = PhLineIndent;
        end else if (!class_i.is_space_tab) begin
          took   = 1'b0;
          reject = 1'b1;
        end
      end
      PhOpenLf: begin
        if (class_i.is_lf) begin
          took    = 1'b1;
          phase_d = PhLineIndent;
        end else begin
          reject = 1'b1;
        end
      end
      PhLineIndent: begin
        took = 1'b1;
      end
      PhCloseFollow: begin
        accept = 1'b1;
      end
      PhSkipLine: begin
        if (class_i.is_end) begin
          reject = 1'b1;
        end else begin
          took = 1'b1;
          if (class_i.is_lf) begin
            phase_d = PhLineIndent;
          end
        end
      end
      default: reject = 1'b1;
    endcase

    if (start_scan_i && !token_allowed_i) begin
      reject = 1'b1;
      took   = 1'b0;
      accept = 1'b0;
    end

    len_inc = (took && (len_base != '1)) ? len_base + 1'b1 : len_base;

    if (reject) begin
      verdict_o = tqbs_pkg::VerdictReject;
      len_shown = '0;
      phase_d   = PhIdle;
      quote_d   = 2'd0;
      len_d     = '0;
    end else if (accept) begin
      verdict_o = tqbs_pkg::VerdictAccept;
      len_shown = len_inc;
      phase_d   = PhIdle;
      quote_d   = 2'd0;
      len_d     = '0;
    end else if (ph == PhIdle) begin
      verdict_o = tqbs_pkg::VerdictIdle;
      len_shown = '0;
      len_d     = len_base;
    end else begin
      verdict_o = tqbs_pkg::VerdictScan;
      len_shown = len_inc;
      len_d     = len_inc;
    end
  end

  assign in_token_o     = took && !reject;
  assign len_ext        = ExtBits'(len_shown);
  assign token_length_o = len_ext[tqbs_pkg::TokenLenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      quote_q <= 2'd0;
      len_q   <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      quote_q <= quote_d;
      len_q   <= len_d;
    end
  end

endmodule

@@ design/triple_quoted_block_string_scanner.sv @@
// ----------------------------------------------------------------------------
// triple_quoted_block_string_scanner
// Character-at-a-time recognizer for triple-quoted block string tokens.
// ----------------------------------------------------------------------------
// One character enters per transfer and produces exactly one result transfer.
// A character passes an input register, is evaluated combinationally by the scan
// state machine and lands in an output register; throughput is one character per
// cycle while the output does not stall, and the only limit is the scan state
// update, which completes in the cycle a character leaves the input register.
// A stall on the output holds the pipeline; the input side keeps accepting
// while the input register can move on or is empty.
module triple_quoted_block_string_scanner #(
  parameter int unsigned LENGTH_BITS = tqbs_pkg::LengthBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tqbs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tqbs_pkg::out_item_t out_item_o
);

  tqbs_pkg::in_item_t   in_item_q;
  logic                 in_vld_q;
  tqbs_pkg::out_item_t  out_item_q, out_item_d;
  logic                 out_vld_q;
  logic                 advance;
  tqbs_pkg::char_class_t cls;
  tqbs_pkg::verdict_e   verdict;

  // A character moves to the output register when the output is free or drains.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  tqbs_char_class u_class (
    .char_code_i    (in_item_q.char_code),
    .end_of_input_i (in_item_q.end_of_input),
    .class_o        (cls)
  );

  tqbs_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .start_scan_i    (in_item_q.start_scan),
    .token_allowed_i (in_item_q.token_allowed),
    .class_i         (cls),
    .verdict_o       (verdict),
    .in_token_o      (out_item_d.in_token),
    .token_length_o  (out_item_d.token_length)
  );

  assign out_item_d.verdict = verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the triple-quoted block string scanner.
// ----------------------------------------------------------------------------
// A short table of directed characters walks the scanner through each stage of
// a token. Random block strings follow, mixed with near misses, cut-off and
// corrupted text and plain noise. Every result transfer is compared with a
// scan model kept in the testbench, or with the result a directed row carries,
// and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import tqbs_pkg::*;

  localparam int unsigned RandChars  = 700;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned MaxReports = 10;

  typedef enum logic [3:0] {
    PhIdle,
    PhLead,
    PhOpenQuotes,
    PhOpenKind,
    PhOpenDash,
    PhOpenSpace,
    PhOpenLf,
    PhLineIndent,
    PhCloseQuotes,
    PhCloseFollow,
    PhSkipLine
  } scan_phase_e;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t result;
  } stim_row_t;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // A directed row may carry its own expected result along with the character.
  logic      row_typed;
  out_item_t row_result;

  // Scan model state.
  scan_phase_e              sc_phase;
  logic [1:0]               sc_quotes;
  logic [LengthBitsDef-1:0] sc_len;

  out_item_t   pending_results[$];
  stim_row_t   stim_table[$];
  out_item_t   predicted;
  out_item_t   want;
  bit          idle_on;
  int unsigned chars_driven;
  int unsigned chars_taken;
  int unsigned results_seen;
  int unsigned accepted_tokens;
  int unsigned rejected_scans;
  int unsigned mismatches;
  int unsigned cycles;

  triple_quoted_block_string_scanner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advances the scan model by one character and returns the result it gives.
  function automatic out_item_t scan_char(input in_item_t it);
    out_item_t  res;
    logic [7:0] c;
    verdict_e   verdict;
    logic       took;
    bit         settled;
    int         iter;
    res     = '0;
    c       = it.end_of_input ? ChNul : it.char_code;
    verdict = VerdictScan;
    took    = 1'b0;
    settled = 1'b0;
    if (it.start_scan) begin
      sc_quotes = '0;
      sc_len    = '0;
      if (!it.token_allowed) begin
        sc_phase    = PhIdle;
        res.verdict = VerdictReject;
        return res;
      end
      sc_phase = PhLead;
    end
    if (sc_phase == PhIdle) begin
      res.verdict = VerdictIdle;
      return res;
    end
    // Some phases hand the same character on to the next phase.
    for (iter = 0; iter < 8 && !settled; iter++) begin
      case (sc_phase)
        PhLead: begin
          if (c inside {ChSpace, ChTab, ChLf, ChCr}) begin
            settled = 1'b1;
          end else begin
            sc_quotes = '0;
            sc_phase  = PhOpenQuotes;
          end
        end
        PhOpenQuotes: begin
          if (c == ChQuote) begin
            took      = 1'b1;
            sc_quotes = sc_quotes + 2'd1;
            if (sc_quotes == 2'd3) begin
              sc_quotes = '0;
              sc_phase  = PhOpenKind;
            end
          end else begin
            verdict = VerdictReject;
          end
          settled = 1'b1;
        end
        PhOpenKind: begin
          if (c inside {ChBar, ChGreater, ChBackslash}) begin
            took     = 1'b1;
            sc_phase = PhOpenDash;
          end else begin
            verdict = VerdictReject;
          end
          settled = 1'b1;
        end
        PhOpenDash: begin
          sc_phase = PhOpenSpace;
          if (c == ChDash) begin
            took    = 1'b1;
            settled = 1'b1;
          end
        end
        PhOpenSpace: begin
          if (c inside {ChSpace, ChTab}) begin
            took = 1'b1;
          end else if (c == ChCr) begin
            took     = 1'b1;
            sc_phase = PhOpenLf;
          end else if (c == ChLf) begin
            took     = 1'b1;
            sc_phase = PhLineIndent;
          end else begin
            verdict = VerdictReject;
          end
          settled = 1'b1;
        end
        PhOpenLf: begin
          if (c == ChLf) begin
            took     = 1'b1;
            sc_phase = PhLineIndent;
          end else begin
            verdict = VerdictReject;
          end
          settled = 1'b1;
        end
        PhLineIndent: begin
          if (c inside {ChSpace, ChTab}) begin
            took    = 1'b1;
            settled = 1'b1;
          end else begin
            sc_quotes = '0;
            sc_phase  = PhCloseQuotes;
          end
        end
        PhCloseQuotes: begin
          if (c == ChQuote) begin
            took      = 1'b1;
            sc_quotes = sc_quotes + 2'd1;
            if (sc_quotes == 2'd3) begin
              sc_quotes = '0;
              sc_phase  = PhCloseFollow;
            end
            settled = 1'b1;
          end else begin
            sc_quotes = '0;
            sc_phase  = PhSkipLine;
          end
        end
        PhCloseFollow: begin
          if (c inside {ChNul, ChLf, ChCr, ChSpace, ChTab, ChComma, ChRParen, ChRBrace,
                        ChRBracket, ChHash}) begin
            verdict = VerdictAccept;
            settled = 1'b1;
          end else begin
            sc_phase = PhSkipLine;
          end
        end
        PhSkipLine: begin
          if (c == ChNul) begin
            verdict = VerdictReject;
          end else begin
            took = 1'b1;
            if (c == ChLf) sc_phase = PhLineIndent;
          end
          settled = 1'b1;
        end
        default: begin
          verdict = VerdictReject;
          settled = 1'b1;
        end
      endcase
    end
    if (verdict == VerdictReject) begin
      sc_phase    = PhIdle;
      sc_quotes   = '0;
      sc_len      = '0;
      res.verdict = VerdictReject;
      return res;
    end
    if (took && sc_len != '1) sc_len = sc_len + 1'b1;
    res.verdict      = verdict;
    res.in_token     = took;
    res.token_length = sc_len[TokenLenW-1:0];
    if (verdict == VerdictAccept) begin
      sc_phase  = PhIdle;
      sc_quotes = '0;
      sc_len    = '0;
    end
    return res;
  endfunction

  function automatic stim_row_t chr(input logic s, input logic a, input logic [7:0] ch,
                                    input logic e);
    stim_row_t r;
    r                    = '0;
    r.item.start_scan    = s;
    r.item.token_allowed = a;
    r.item.char_code     = ch;
    r.item.end_of_input  = e;
    return r;
  endfunction

  function automatic stim_row_t chr_exp(input logic s, input logic a, input logic [7:0] ch,
                                        input logic e, input verdict_e v, input logic t,
                                        input logic [TokenLenW-1:0] len);
    stim_row_t r;
    r                     = chr(s, a, ch, e);
    r.typed               = 1'b1;
    r.result.verdict      = v;
    r.result.in_token     = t;
    r.result.token_length = len;
    return r;
  endfunction

  function automatic logic [7:0] indent_char();
    return $urandom_range(0, 1) ? ChSpace : ChTab;
  endfunction

  function automatic logic [7:0] lead_char();
    case ($urandom_range(0, 3))
      0: return ChSpace;
      1: return ChTab;
      2: return ChCr;
      default: return ChLf;
    endcase
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    case ($urandom_range(0, 5))
      0: b = ChQuote;
      1: b = indent_char();
      default: b = 8'($urandom_range(1, 255));
    endcase
    // A line feed here would end the line early.
    if (b == ChLf) b = ChCr;
    return b;
  endfunction

  function automatic logic [7:0] close_follower();
    case ($urandom_range(0, 8))
      0: return ChLf;
      1: return ChCr;
      2: return ChSpace;
      3: return ChTab;
      4: return ChComma;
      5: return ChRParen;
      6: return ChRBrace;
      7: return ChRBracket;
      default: return ChHash;
    endcase
  endfunction

  task automatic report_error(input string what, input out_item_t exp_res,
                              input out_item_t got);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("ERROR at %0t: %s: expected verdict %0d in_token %0b length %0d, got %0d %0b %0d",
               $realtime, what, exp_res.verdict, exp_res.in_token, exp_res.token_length,
               got.verdict, got.in_token, got.token_length);
  endtask

  task automatic send_char(input stim_row_t r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    in_item    <= r.item;
    row_typed  <= r.typed;
    row_result <= r.result;
    do @(posedge clk_i); while (in_stall);
    chars_driven++;
  endtask

  // Sends one block string with random content; some are cut off or damaged.
  task automatic send_block_token();
    logic [7:0]  text[$];
    bit          end_close;
    int unsigned cut;
    int unsigned k;
    text = {};
    repeat ($urandom_range(0, 2)) text.push_back(lead_char());
    repeat (3) text.push_back(ChQuote);
    case ($urandom_range(0, 2))
      0: text.push_back(ChBar);
      1: text.push_back(ChGreater);
      default: text.push_back(ChBackslash);
    endcase
    if ($urandom_range(0, 1)) text.push_back(ChDash);
    repeat ($urandom_range(0, 2)) text.push_back(indent_char());
    if ($urandom_range(0, 1)) text.push_back(ChCr);
    text.push_back(ChLf);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 2)) text.push_back(indent_char());
      // Lines that look like a closing delimiter and then miss it.
      case ($urandom_range(0, 3))
        0: begin
          repeat (3) text.push_back(ChQuote);
          text.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
        1: repeat (2) text.push_back(ChQuote);
        default: ;
      endcase
      repeat ($urandom_range(0, 5)) text.push_back(body_byte());
      text.push_back(ChLf);
    end
    repeat ($urandom_range(0, 2)) text.push_back(indent_char());
    repeat (3) text.push_back(ChQuote);
    end_close = ($urandom_range(0, 3) == 0);
    if (!end_close) text.push_back(close_follower());
    if ($urandom_range(0, 5) == 0)
      text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
    cut = text.size();
    if ($urandom_range(0, 7) == 0) begin
      cut       = $urandom_range(1, text.size() - 1);
      end_close = 1'b1;
    end
    for (k = 0; k < cut; k++)
      send_char(chr(k == 0,
                    (k == 0) ? ($urandom_range(0, 7) != 0) : 1'($urandom_range(0, 1)),
                    text[k], 1'b0));
    if (end_close)
      send_char(chr(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1));
  endtask

  task automatic send_noise();
    int unsigned n;
    int unsigned k;
    n = $urandom_range(1, 8);
    for (k = 0; k < n; k++)
      send_char(chr($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0));
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("triple_quoted_block_string_scanner verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        predicted = scan_char(in_item);
        pending_results.push_back(row_typed ? row_result : predicted);
        chars_taken++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_item.verdict == VerdictAccept) accepted_tokens++;
        if (out_item.verdict == VerdictReject) rejected_scans++;
        if (pending_results.size() == 0) begin
          report_error("result with nothing pending", '0, out_item);
        end else begin
          want = pending_results.pop_front();
          if (out_item.verdict !== want.verdict || out_item.in_token !== want.in_token ||
              out_item.token_length !== want.token_length)
            report_error("result mismatch", want, out_item);
        end
      end
    end
  end

  initial begin : result_stall
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      hold = idle_on ? $urandom_range(0, 3) : 0;
      repeat (hold) begin
        out_stall <= 1'b1;
        @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    in_valid   <= 1'b0;
    in_item    <= '0;
    row_typed  <= 1'b0;
    row_result <= '0;
    sc_phase  = PhIdle;
    sc_quotes = '0;
    sc_len    = '0;
    idle_on   = 1'b1;

    stim_table.push_back(chr_exp(1'b0, 1'b0, 8'h41, 1'b0, VerdictIdle, 1'b0, '0));
    stim_table.push_back(chr_exp(1'b1, 1'b0, ChQuote, 1'b0, VerdictReject, 1'b0, '0));
    stim_table.push_back(chr(1'b1, 1'b1, ChSpace, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b1, ChTab, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b0, ChCr, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b0, ChLf, 1'b0));
    repeat (3) stim_table.push_back(chr(1'b0, 1'b0, ChQuote, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b0, ChBar, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b0, ChDash, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b1, ChTab, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b0, ChCr, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b0, ChLf, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b0, ChSpace, 1'b0));
    // One quote and then a letter: the line is skipped, not closed.
    stim_table.push_back(chr(1'b0, 1'b0, ChQuote, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b0, 8'h62, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b0, ChLf, 1'b0));
    repeat (3) stim_table.push_back(chr(1'b0, 1'b0, ChQuote, 1'b0));
    stim_table.push_back(chr(1'b0, 1'b1, ChRBracket, 1'b0));
    // A new start in the middle of a scan begins over.
    stim_table.push_back(chr(1'b1, 1'b1, ChQuote, 1'b0));
    stim_table.push_back(chr(1'b1, 1'b1, ChQuote, 1'b0));
    stim_table.push_back(chr_exp(1'b0, 1'b1, 8'hFF, 1'b1, VerdictReject, 1'b0, '0));
    stim_table.push_back(chr_exp(1'b0, 1'b1, ChNul, 1'b0, VerdictIdle, 1'b0, '0));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) send_char(stim_table[i]);

    while (chars_driven < stim_table.size() + RandChars) begin
      if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 9) < 7) send_block_token();
      else send_noise();
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Scanned %0d characters into %0d results: %0d block strings accepted, %0d rejected.",
             chars_taken, results_seen, accepted_tokens, rejected_scans);
    $display("Directed steps, random block strings, near misses, cut-off text and noise ran.");
    if (mismatches == 0) begin
      $display("triple_quoted_block_string_scanner verification clean");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("triple_quoted_block_string_scanner verification failed");
    end
    $finish;
  end

endmodule
